// ===== rtl/multilevel_ready_queue_scheduler_top_macros.svh =====
// Assertion macros shared by the scheduler checker.
// No dependencies; included by mrqs_checker.sv.
`ifndef MULTILEVEL_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define MULTILEVEL_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MRQS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define MRQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

// ===== rtl/mrqs_pkg.sv =====
// Package for the multilevel ready queue scheduler: sizes, codes and structs.
// No dependencies; used by the top level, the cell and the checker.
`timescale 1ns / 1ps

package mrqs_pkg;

   localparam int NUM_PROCESSES = 16;
   localparam int NUM_LEVELS    = 4;

   localparam int ACT_W = 3;
   localparam int PID_W = 4;
   localparam int LVL_W = 2;
   localparam int STA_W = 2;
   localparam int IDX_W = $clog2(NUM_PROCESSES);
   localparam int CNT_W = $clog2(NUM_PROCESSES + 1);

   localparam logic [ACT_W-1:0] ACT_ENQUEUE  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DEQUEUE  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SET_PRIO = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SET_STAT = 3'd3;
   localparam logic [ACT_W-1:0] ACT_GET_PRIO = 3'd4;

   localparam logic [STA_W-1:0] STAT_NEW         = 2'd0;
   localparam logic [STA_W-1:0] STAT_READY       = 2'd1;
   localparam logic [STA_W-1:0] STAT_MEM_BLOCKED = 2'd2;
   localparam logic [STA_W-1:0] STAT_MSG_BLOCKED = 2'd3;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_APPLY
   } fsm_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [PID_W-1:0] pid;
      logic [LVL_W-1:0] new_priority;
      logic [STA_W-1:0] proc_status;
      logic             mem_free;
      logic [PID_W-1:0] running_pid;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [PID_W-1:0] chosen_pid;
      logic [LVL_W-1:0] priority_out;
      logic             error;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [PID_W-1:0] pid;
      logic [LVL_W-1:0] level;
      logic [STA_W-1:0] status;
   } entry_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [LVL_W-1:0] level;
      logic [IDX_W-1:0] idx;
      logic [PID_W-1:0] pid;
      logic [STA_W-1:0] status;
   } token_type;

   typedef struct packed {
      logic             remove_en;
      logic [IDX_W-1:0] remove_idx;
      logic             append_en;
      logic [IDX_W-1:0] append_idx;
      entry_type        append_entry;
      logic             status_en;
      logic [PID_W-1:0] status_pid;
      logic [STA_W-1:0] status_val;
      logic             mem_ok;
   } upd_type;

endpackage

// ===== rtl/multilevel_ready_queue_scheduler_top.sv =====
// Top level of the multilevel ready queue scheduler: control, tables and cell row.
// Depends on mrqs_pkg and mrqs_cell.
//
//   channel   ports              direction   moves
//   request   req_valid/ready    in          req_type: action, pid, levels, status
//   response  rsp_valid/ready    out         rsp_type: found, chosen_pid, priority, error
//
// Dequeue runs from acceptance to the next acceptance in steps: launch the search token,
// let it climb the 16 slots, capture the winner, then unlink it. Every other action goes
// straight to the apply step. One transaction is in flight at a time; a new one is
// accepted while a result waits, and a stalled response holds the apply step.
// Synchronous reset empties every slot and sets all processes to level 0, status new.
`timescale 1ns / 1ps

module multilevel_ready_queue_scheduler_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mrqs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mrqs_pkg::rsp_type rsp_data
);

   localparam int N = mrqs_pkg::NUM_PROCESSES;

   mrqs_pkg::fsm_type   state_ff, state_in;
   mrqs_pkg::req_type   req_ff;
   mrqs_pkg::token_type dq_ff;
   logic                scan_start_ff, scan_start_in;
   logic [mrqs_pkg::CNT_W-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mrqs_pkg::rsp_type   rsp_data_ff, rsp_new;

   logic [mrqs_pkg::LVL_W-1:0] level_tab_ff [N];
   logic [mrqs_pkg::STA_W-1:0] state_tab_ff [N];

   mrqs_pkg::entry_type ent [N];
   mrqs_pkg::entry_type upper [N];
   mrqs_pkg::token_type tok [N];
   mrqs_pkg::token_type tok_chain [N];
   mrqs_pkg::upd_type   upd;

   logic [mrqs_pkg::IDX_W-1:0] rid;
   logic [mrqs_pkg::LVL_W-1:0] cur_level;
   logic [mrqs_pkg::STA_W-1:0] cur_status;
   logic                queued;
   logic [mrqs_pkg::IDX_W-1:0] match_idx;
   logic                pid_ok;
   logic                lvl_ok;
   logic                out_free;
   logic                apply_fire;
   logic                lvl_we;
   logic                st_we;
   logic [mrqs_pkg::IDX_W-1:0] st_waddr;
   logic [mrqs_pkg::STA_W-1:0] st_wdata;

   assign rid        = mrqs_pkg::IDX_W'(req_ff.pid);
   assign cur_level  = level_tab_ff[rid];
   assign cur_status = state_tab_ff[rid];
   assign pid_ok     = int'(req_ff.pid) < mrqs_pkg::NUM_PROCESSES;
   assign lvl_ok     = int'(req_ff.new_priority) < mrqs_pkg::NUM_LEVELS;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      queued    = 1'b0;
      match_idx = '0;
      for (int j = 0; j < N; j++) begin
         if (ent[j].valid && (ent[j].pid == req_ff.pid)) begin
            queued    = 1'b1;
            match_idx = match_idx | mrqs_pkg::IDX_W'(j);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      scan_start_in = 1'b0;
      apply_fire    = 1'b0;
      upd           = '0;
      rsp_new       = '0;
      lvl_we        = 1'b0;
      st_we         = 1'b0;
      st_waddr      = rid;
      st_wdata      = req_ff.proc_status;
      case (state_ff)
         mrqs_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.action == mrqs_pkg::ACT_DEQUEUE) begin
                  scan_start_in = 1'b1;
                  state_in      = mrqs_pkg::FSM_SCAN;
               end else begin
                  state_in = mrqs_pkg::FSM_APPLY;
               end
            end
         end
         mrqs_pkg::FSM_SCAN: begin
            if (tok[N-1].valid) begin
               state_in = mrqs_pkg::FSM_APPLY;
            end
         end
         mrqs_pkg::FSM_APPLY: begin
            if (out_free) begin
               apply_fire = 1'b1;
               state_in   = mrqs_pkg::FSM_IDLE;
               case (req_ff.action)
                  mrqs_pkg::ACT_ENQUEUE: begin
                     if (!pid_ok) begin
                        rsp_new.error = 1'b1;
                     end else if (!queued) begin
                        rsp_new.found             = 1'b1;
                        upd.append_en             = 1'b1;
                        upd.append_entry.valid    = 1'b1;
                        upd.append_entry.pid      = req_ff.pid;
                        upd.append_entry.level    = cur_level;
                        upd.append_entry.status   = cur_status;
                     end
                  end
                  mrqs_pkg::ACT_DEQUEUE: begin
                     if (dq_ff.found) begin
                        rsp_new.found      = 1'b1;
                        rsp_new.chosen_pid = dq_ff.pid;
                        upd.remove_en      = 1'b1;
                        upd.remove_idx     = dq_ff.idx;
                        st_waddr           = mrqs_pkg::IDX_W'(dq_ff.pid);
                        st_wdata           = mrqs_pkg::STAT_READY;
                        st_we              = dq_ff.status == mrqs_pkg::STAT_MEM_BLOCKED;
                     end
                  end
                  mrqs_pkg::ACT_SET_PRIO: begin
                     if (!pid_ok || !lvl_ok) begin
                        rsp_new.error = 1'b1;
                     end else begin
                        rsp_new.found = 1'b1;
                        if (cur_level != req_ff.new_priority) begin
                           lvl_we = 1'b1;
                           if (queued) begin
                              upd.remove_en  = 1'b1;
                              upd.remove_idx = match_idx;
                              if (req_ff.pid != req_ff.running_pid) begin
                                 upd.append_en           = 1'b1;
                                 upd.append_entry.valid  = 1'b1;
                                 upd.append_entry.pid    = req_ff.pid;
                                 upd.append_entry.level  = req_ff.new_priority;
                                 upd.append_entry.status = cur_status;
                              end
                           end
                        end
                     end
                  end
                  mrqs_pkg::ACT_SET_STAT: begin
                     if (!pid_ok) begin
                        rsp_new.error = 1'b1;
                     end else begin
                        rsp_new.found  = 1'b1;
                        st_we          = 1'b1;
                        upd.status_en  = 1'b1;
                        upd.status_pid = req_ff.pid;
                        upd.status_val = req_ff.proc_status;
                     end
                  end
                  mrqs_pkg::ACT_GET_PRIO: begin
                     if (!pid_ok) begin
                        rsp_new.error = 1'b1;
                     end else begin
                        rsp_new.found        = 1'b1;
                        rsp_new.priority_out = cur_level;
                     end
                  end
                  default: begin
                     rsp_new = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = mrqs_pkg::FSM_IDLE;
         end
      endcase
      upd.mem_ok     = req_ff.mem_free;
      upd.append_idx = mrqs_pkg::IDX_W'(count_ff - mrqs_pkg::CNT_W'(upd.remove_en));
      count_in       = count_ff - mrqs_pkg::CNT_W'(upd.remove_en)
                       + mrqs_pkg::CNT_W'(upd.append_en);
      rsp_valid_in   = apply_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mrqs_pkg::FSM_IDLE;
         scan_start_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int j = 0; j < N; j++) begin
            level_tab_ff[j] <= '0;
            state_tab_ff[j] <= mrqs_pkg::STAT_NEW;
         end
      end else begin
         state_ff      <= state_in;
         scan_start_ff <= scan_start_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (lvl_we) begin
            level_tab_ff[rid] <= req_ff.new_priority;
         end
         if (st_we) begin
            state_tab_ff[st_waddr] <= st_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if ((state_ff == mrqs_pkg::FSM_SCAN) && tok[N-1].valid) begin
         dq_ff <= tok[N-1];
      end
      if (apply_fire) begin
         rsp_data_ff <= rsp_new;
      end
   end

   always_comb begin
      for (int j = 0; j < N; j++) begin
         if (j == 0) begin
            tok_chain[j]       = '0;
            tok_chain[j].valid = scan_start_ff;
         end else begin
            tok_chain[j] = tok[j-1];
         end
         if (j == N - 1) begin
            upper[j] = '0;
         end else begin
            upper[j] = ent[j+1];
         end
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      mrqs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (mrqs_pkg::IDX_W'(g)),
         .upd      (upd),
         .upper    (upper[g]),
         .tok_in   (tok_chain[g]),
         .ent_out  (ent[g]),
         .tok_out  (tok[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/mrqs_cell.sv =====
// One queue slot: holds a queued process and passes the search token upward.
// Depends on mrqs_pkg.
`timescale 1ns / 1ps

module mrqs_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [mrqs_pkg::IDX_W-1:0] cell_idx,
   input  mrqs_pkg::upd_type         upd,
   input  mrqs_pkg::entry_type       upper,
   input  mrqs_pkg::token_type       tok_in,
   output mrqs_pkg::entry_type       ent_out,
   output mrqs_pkg::token_type       tok_out
);

   mrqs_pkg::entry_type entry_ff, entry_in;
   mrqs_pkg::token_type tok_ff, tok_in_next;
   logic                elig;
   logic                take;

   always_comb begin
      elig = entry_ff.valid && (entry_ff.status != mrqs_pkg::STAT_MSG_BLOCKED) &&
             ((entry_ff.status != mrqs_pkg::STAT_MEM_BLOCKED) || upd.mem_ok);
      take = tok_in.valid && elig && (!tok_in.found || (entry_ff.level < tok_in.level));
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found  = 1'b1;
         tok_in_next.level  = entry_ff.level;
         tok_in_next.idx    = cell_idx;
         tok_in_next.pid    = entry_ff.pid;
         tok_in_next.status = entry_ff.status;
      end

      entry_in = entry_ff;
      if (upd.append_en && (cell_idx == upd.append_idx)) begin
         entry_in = upd.append_entry;
      end else if (upd.remove_en && (cell_idx >= upd.remove_idx)) begin
         entry_in = upper;
      end
      if (upd.status_en && entry_in.valid && (entry_in.pid == upd.status_pid)) begin
         entry_in.status = upd.status_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         tok_ff.valid   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         tok_ff   <= tok_in_next;
      end
   end

   assign ent_out = entry_ff;
   assign tok_out = tok_ff;

endmodule

// ===== rtl/mrqs_checker.sv =====
// Port-level checks for the scheduler top level, attached by bind.
// Depends on mrqs_pkg and multilevel_ready_queue_scheduler_top_macros.svh.
`timescale 1ns / 1ps
`include "multilevel_ready_queue_scheduler_top_macros.svh"

module mrqs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mrqs_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mrqs_pkg::rsp_type rsp_data
);

   logic req_fire;
   logic req_wait;
   logic rsp_stall;
   logic rsp_zero;

   assign req_fire  = req_valid && req_ready;
   assign req_wait  = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_zero  = !rsp_data.found && (rsp_data.chosen_pid == '0)
                      && (rsp_data.priority_out == '0);

   `MRQS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `MRQS_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_data))
   `MRQS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_ready)
   `MRQS_ASSERT_NOW(a_error_clean, clock, reset, rsp_valid && rsp_data.error, rsp_zero)
   `MRQS_ASSERT_NOW(a_chosen_found, clock, reset, rsp_valid && (rsp_data.chosen_pid != 0), rsp_data.found)

endmodule

bind multilevel_ready_queue_scheduler_top mrqs_checker u_mrqs_checker (.*);
